FILE: hdl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// shared constants and types for the pixel to camera ray pipeline
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int SCREEN_DIM_BITS = 12;
  localparam int DIR_FRAC_BITS   = 15;

  // port widths
  localparam int PIX_W      = 16;
  localparam int DIM_W      = 13;
  localparam int TAN_W      = 16;
  localparam int DIR_W      = DIR_FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENT = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET   = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET  = 13'd480;
  localparam logic [TAN_W-1:0] TANGENT_RESET = 16'd6786;

  // internal widths
  localparam int CDIM_W   = SCREEN_DIM_BITS + 1;
  localparam int CMP_W    = (CDIM_W > DIM_W) ? CDIM_W : DIM_W;
  localparam int TWOPIX_W = PIX_W + 1;
  localparam int DIM16_W  = SCREEN_DIM_BITS + 5;
  localparam int DIFF_W   = (TWOPIX_W > DIM16_W) ? TWOPIX_W : DIM16_W;
  localparam int PROD_W   = DIFF_W + TAN_W;
  localparam int ZSHIFT   = 18;
  localparam int MC_W     = CDIM_W + ZSHIFT;
  localparam int MX_W     = (PROD_W > MC_W) ? PROD_W : MC_W;
  localparam int MAG_W    = 31;
  localparam int SH_W     = $clog2(MX_W - MAG_W + 1);
  localparam int SUM_W    = 2 * MAG_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int ROOT_W   = MAG_W + 1;
  localparam int NUM_W    = MAG_W + DIR_FRAC_BITS + 1;
  localparam int Q_STEPS  = DIR_W;

  // scaled vector carried down the pipe
  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [MAG_W-1:0] c;
    logic             na;
    logic             nb;
  } vec_t;

  // long division state for all three components
  typedef struct packed {
    logic [NUM_W-1:0] ra;
    logic [NUM_W-1:0] rb;
    logic [NUM_W-1:0] rc;
    logic [DIR_W-1:0] qa;
    logic [DIR_W-1:0] qb;
    logic [DIR_W-1:0] qc;
    logic             na;
    logic             nb;
  } div_t;

endpackage

FILE: hdl/prc_if.sv
// ----------------------------------------------------------------------------
// prc_pix_if / prc_dir_if
// valid/ready channels for pixel positions and ray directions
// ----------------------------------------------------------------------------
interface prc_pix_if import prc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface prc_dir_if import prc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

FILE: hdl/pixel_to_camera_ray.sv
// ----------------------------------------------------------------------------
// pixel_to_camera_ray
// pinhole camera: unit ray direction in Q1.15 for a Q12.4 pixel position
// ----------------------------------------------------------------------------
// channel   dir   content                          width
// pix       in    pixel_x, pixel_y (Q12.4)         16 + 16
// dir       out   dir_x, dir_y, dir_z (Q1.15)      16 + 16 + 16
// cfg       in    cfg_we, cfg_idx, cfg_data        1 + 2 + 16
//
// one beat per cycle sustained while the output is taken; the pipe depth is
// set by the one-pair-per-stage square root and one-bit-per-stage divider
// every stage moves on a shared advance, which holds only while the output
// register is full and not taken; nothing is dropped or repeated
// synchronous reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module pixel_to_camera_ray import prc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  prc_pix_if.sink               pix,
  prc_dir_if.source             dir
);

  // configuration registers
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [TAN_W-1:0] half_fov_tangent;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= WIDTH_RESET;
      screen_height    <= HEIGHT_RESET;
      half_fov_tangent <= TANGENT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:   screen_width     <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:  screen_height    <= cfg_data[DIM_W-1:0];
        REG_TANGENT: half_fov_tangent <= cfg_data[TAN_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the output beat is stuck
  logic adv;
  logic out_valid;
  assign adv       = !out_valid || dir.ready;
  assign pix.ready = adv;

  // zero dims act as one, oversized ones clip to the screen limit
  function automatic logic [CDIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [CMP_W-1:0] vx;
    logic [CMP_W-1:0] lim;
    vx  = CMP_W'(v);
    lim = CMP_W'(1) << SCREEN_DIM_BITS;
    if (vx == '0)      clamp_dim = CDIM_W'(1);
    else if (vx > lim) clamp_dim = CDIM_W'(lim);
    else               clamp_dim = CDIM_W'(vx);
  endfunction

  // stage 0: centred offsets in half-pixel Q.4 units
  logic [CDIM_W-1:0] w_c, h_c;
  logic [DIFF_W-1:0] two_px, two_py, w16, h16;
  assign w_c    = clamp_dim(screen_width);
  assign h_c    = clamp_dim(screen_height);
  assign two_px = DIFF_W'({pix.pixel_x, 1'b0});
  assign two_py = DIFF_W'({pix.pixel_y, 1'b0});
  assign w16    = DIFF_W'(w_c) << 4;
  assign h16    = DIFF_W'(h_c) << 4;

  logic              s0_vld;
  logic [DIFF_W-1:0] s0_ma, s0_mb;
  logic              s0_na, s0_nb;
  logic [CDIM_W-1:0] s0_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (two_px >= w16) begin
        s0_ma <= two_px - w16;
        s0_na <= 1'b0;
      end else begin
        s0_ma <= w16 - two_px;
        s0_na <= 1'b1;
      end
      // screen y flipped to upward
      if (h16 >= two_py) begin
        s0_mb <= h16 - two_py;
        s0_nb <= 1'b0;
      end else begin
        s0_mb <= two_py - h16;
        s0_nb <= 1'b1;
      end
      s0_m <= (w_c < h_c) ? w_c : h_c;
    end
  end

  // stage 1: scale by the tangent, z from the smaller side
  logic              s1_vld;
  logic [MX_W-1:0]   s1_pa, s1_pb, s1_pc;
  logic              s1_na, s1_nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pa <= MX_W'(PROD_W'(s0_ma) * PROD_W'(half_fov_tangent));
      s1_pb <= MX_W'(PROD_W'(s0_mb) * PROD_W'(half_fov_tangent));
      s1_pc <= MX_W'(s0_m) << ZSHIFT;
      s1_na <= s0_na;
      s1_nb <= s0_nb;
    end
  end

  // stage 2: common right shift bringing every magnitude under 2^31
  logic [MX_W-1:0] any_bits;
  logic [SH_W-1:0] sh;
  logic [MX_W-1:0] sa, sb, sc;
  assign any_bits = s1_pa | s1_pb | s1_pc;

  always_comb begin
    sh = '0;
    for (int j = MAG_W; j < MX_W; j++) begin
      if (any_bits[j]) sh = SH_W'(j - MAG_W + 1);
    end
  end

  assign sa = s1_pa >> sh;
  assign sb = s1_pb >> sh;
  assign sc = s1_pc >> sh;

  logic s2_vld;
  vec_t s2_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_vec.a  <= sa[MAG_W-1:0];
      s2_vec.b  <= sb[MAG_W-1:0];
      s2_vec.c  <= sc[MAG_W-1:0];
      // a zero component carries no sign
      s2_vec.na <= s1_na && (sa[MAG_W-1:0] != '0);
      s2_vec.nb <= s1_nb && (sb[MAG_W-1:0] != '0);
    end
  end

  // stage 3: squares
  logic                 s3_vld;
  vec_t                 s3_vec;
  logic [2*MAG_W-1:0]   s3_qa, s3_qb, s3_qc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_qa  <= s2_vec.a * s2_vec.a;
      s3_qb  <= s2_vec.b * s2_vec.b;
      s3_qc  <= s2_vec.c * s2_vec.c;
      s3_vec <= s2_vec;
    end
  end

  // stage 4: sum of squares
  logic             s4_vld;
  vec_t             s4_vec;
  logic [SUM_W-1:0] s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sum <= SUM_W'(s3_qa) + SUM_W'(s3_qb) + SUM_W'(s3_qc);
      s4_vec <= s3_vec;
    end
  end

  // integer square root, one result bit per stage
  logic             rt_vld [ROOT_STEPS+1];
  vec_t             rt_vec [ROOT_STEPS+1];
  logic [SUM_W-1:0] rt_v   [ROOT_STEPS+1];
  logic [SUM_W-1:0] rt_r   [ROOT_STEPS+1];

  assign rt_vld[0] = s4_vld;
  assign rt_vec[0] = s4_vec;
  assign rt_v[0]   = s4_sum;
  assign rt_r[0]   = '0;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    logic [SUM_W-1:0] bitv, trial;
    assign bitv  = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    assign trial = rt_r[k] + bitv;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_vld[k+1] <= 1'b0;
      end else if (adv) begin
        rt_vld[k+1] <= rt_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_vec[k+1] <= rt_vec[k];
        if (rt_v[k] >= trial) begin
          rt_v[k+1] <= rt_v[k] - trial;
          rt_r[k+1] <= (rt_r[k] >> 1) + bitv;
        end else begin
          rt_v[k+1] <= rt_v[k];
          rt_r[k+1] <= rt_r[k] >> 1;
        end
      end
    end
  end

  // numerators with half the root added for rounding
  logic [ROOT_W-1:0] root;
  assign root = (rt_r[ROOT_STEPS][ROOT_W-1:0] == '0) ? ROOT_W'(1)
                                                     : rt_r[ROOT_STEPS][ROOT_W-1:0];

  logic              dv_vld [Q_STEPS+1];
  div_t              dv_st  [Q_STEPS+1];
  logic [ROOT_W-1:0] dv_r   [Q_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= rt_vld[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_st[0].ra <= (NUM_W'(rt_vec[ROOT_STEPS].a) << DIR_FRAC_BITS) + NUM_W'(root >> 1);
      dv_st[0].rb <= (NUM_W'(rt_vec[ROOT_STEPS].b) << DIR_FRAC_BITS) + NUM_W'(root >> 1);
      dv_st[0].rc <= (NUM_W'(rt_vec[ROOT_STEPS].c) << DIR_FRAC_BITS) + NUM_W'(root >> 1);
      dv_st[0].qa <= '0;
      dv_st[0].qb <= '0;
      dv_st[0].qc <= '0;
      dv_st[0].na <= rt_vec[ROOT_STEPS].na;
      dv_st[0].nb <= rt_vec[ROOT_STEPS].nb;
      dv_r[0]     <= root;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar i = 0; i < Q_STEPS; i++) begin : g_div
    localparam int B = Q_STEPS - 1 - i;
    logic [NUM_W:0]   dsh;
    logic [DIR_W-1:0] qbit;
    logic             ga, gb, gc;
    assign dsh  = (NUM_W + 1)'(dv_r[i]) << B;
    assign qbit = DIR_W'(1) << B;
    assign ga   = {1'b0, dv_st[i].ra} >= dsh;
    assign gb   = {1'b0, dv_st[i].rb} >= dsh;
    assign gc   = {1'b0, dv_st[i].rc} >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[i+1]     <= dv_r[i];
        dv_st[i+1].na <= dv_st[i].na;
        dv_st[i+1].nb <= dv_st[i].nb;
        dv_st[i+1].ra <= ga ? dv_st[i].ra - dsh[NUM_W-1:0] : dv_st[i].ra;
        dv_st[i+1].rb <= gb ? dv_st[i].rb - dsh[NUM_W-1:0] : dv_st[i].rb;
        dv_st[i+1].rc <= gc ? dv_st[i].rc - dsh[NUM_W-1:0] : dv_st[i].rc;
        dv_st[i+1].qa <= ga ? dv_st[i].qa | qbit : dv_st[i].qa;
        dv_st[i+1].qb <= gb ? dv_st[i].qb | qbit : dv_st[i].qb;
        dv_st[i+1].qc <= gc ? dv_st[i].qc | qbit : dv_st[i].qc;
      end
    end
  end

  // saturate: +1.0 clips to just below one, -1.0 stays
  function automatic logic [DIR_W-1:0] sat_comp(input logic [DIR_W-1:0] q, input logic neg);
    logic [DIR_W-1:0] one;
    one = DIR_W'(1) << DIR_FRAC_BITS;
    if (neg) sat_comp = (q > one) ? -one : -q;
    else     sat_comp = (q > one - DIR_W'(1)) ? one - DIR_W'(1) : q;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[Q_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir.dir_x <= sat_comp(dv_st[Q_STEPS].qa, dv_st[Q_STEPS].na);
      dir.dir_y <= sat_comp(dv_st[Q_STEPS].qb, dv_st[Q_STEPS].nb);
      dir.dir_z <= sat_comp(dv_st[Q_STEPS].qc, 1'b1);
    end
  end

  assign dir.valid = out_valid;

  // checks
  a_z_negative: assert property (@(posedge clk) disable iff (rst)
    dir.valid |-> dir.dir_z[DIR_W-1])
    else $error("dir_z not negative");

  a_z_nonzero: assert property (@(posedge clk) disable iff (rst)
    dir.valid |-> (dir.dir_z != '0))
    else $error("dir_z is zero");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (dir.valid && !dir.ready) |-> !pix.ready)
    else $error("input taken while output stalled");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    (dir.valid && !dir.ready) |=> $stable(dv_st[Q_STEPS]))
    else $error("pipe moved during stall");

endmodule
